>>> hdl/zone_attribute_lookup_top_defines.svh
// Assertion macros used by the checker file of the zone lookup block.
`ifndef ZONE_ATTRIBUTE_LOOKUP_TOP_DEFINES_SVH
`define ZONE_ATTRIBUTE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ZAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone lookup check failed");

// Next-cycle implication, disabled while reset is low.
`define ZAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zone lookup check failed");

`endif

>>> hdl/zal_pkg.sv
package zal_pkg;

    localparam int ZONES_DEF = 256;
    localparam int Q_DEPTH   = 2;
    localparam int CNT_OUT_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CAMERA = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROPPED = 2'd2;

    localparam logic [9:0]  REFRESH_RST = 10'd10;
    localparam logic [9:0]  MARGIN_RST  = 10'd30;
    localparam logic [15:0] DROPPED_RST = 16'd0;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic signed [15:0] edge1_x;
        logic signed [15:0] edge1_y;
        logic signed [15:0] edge2_x;
        logic signed [15:0] edge2_y;
        logic signed [15:0] top_z;
        logic [15:0]        zone_flags;
    } t_in;

    typedef struct packed {
        logic [15:0] found_flags;
        logic        refreshed;
        logic        table_full;
        logic [8:0]  zone_total;
        logic [8:0]  near_total;
    } t_out;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SKIP,
        OP_CAMERA,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op op;
        t_in item;
    } t_cmd;

    typedef struct packed {
        logic [9:0]  refresh_distance;
        logic [9:0]  near_margin;
        logic [15:0] dropped_flags;
    } t_cfg;

    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [19:0] bot;
        logic signed [19:0] top16;
        logic signed [15:0] e1x;
        logic signed [15:0] e1y;
        logic signed [15:0] e2x;
        logic signed [15:0] e2y;
        logic [15:0]        flags;
    } t_zone;

endpackage

>>> hdl/zone_attribute_lookup_top.sv
// Zone attribute lookup. Holds up to ZONES prism zones and answers three kinds
// of transaction, one result each: add zone, camera position and point query.
// Items enter a two-entry queue, so a new transaction is accepted while the
// previous result still waits at the output. A query, and a camera position
// that triggers a rebuild, sweep the table, reading one zone per cycle
// through the single read port of the zone memory. The zone memory needs
// no clearing pass after reset. Configuration writes are always ready and
// must only be issued while the block is idle.
module zone_attribute_lookup_top #(
    parameter int ZONES = zal_pkg::ZONES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  zal_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output zal_pkg::t_out                  o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [zal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [zal_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import zal_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid;
    t_cmd  q_cmd;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refresh_distance <= REFRESH_RST;
            r_cfg.near_margin      <= MARGIN_RST;
            r_cfg.dropped_flags    <= DROPPED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REFRESH: r_cfg.refresh_distance <= i_cfg_data[9:0];
                CFG_MARGIN:  r_cfg.near_margin      <= i_cfg_data[9:0];
                CFG_DROPPED: r_cfg.dropped_flags    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    zal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    zal_back #(
        .ZONES (ZONES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> hdl/zal_front.sv
module zal_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  zal_pkg::t_in  i_in,
    input  zal_pkg::t_cfg i_cfg,
    output logic          o_q_valid,
    output zal_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import zal_pkg::*;

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_cnt;
    t_cmd             cls_cmd;
    logic             push;
    logic [15:0]      kept_flags;

    // An add whose flags are all dropped changes nothing, so it is classified as a skip.
    always_comb begin
        kept_flags           = i_in.zone_flags & ~i_cfg.dropped_flags;
        cls_cmd.item         = i_in;
        cls_cmd.item.zone_flags = kept_flags;
        unique case (i_in.func)
            FUNC_ADD:    cls_cmd.op = (kept_flags != 16'd0) ? OP_ADD : OP_SKIP;
            FUNC_CAMERA: cls_cmd.op = OP_CAMERA;
            FUNC_QUERY:  cls_cmd.op = OP_QUERY;
            default:     cls_cmd.op = OP_SKIP;
        endcase
    end

    assign o_in_stall = (r_cnt == QCW'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hdl/zal_back.sv
module zal_back #(
    parameter int ZONES = zal_pkg::ZONES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  zal_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  zal_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output zal_pkg::t_out o_out
);
    import zal_pkg::*;

    localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CW = $clog2(ZONES + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_SQ    = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    function automatic logic signed [16:0] neg_sum(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        logic signed [16:0] ae;
        logic signed [16:0] be;
        ae = a;
        be = b;
        return (ae[16] ? ae : 17'sd0) + (be[16] ? be : 17'sd0);
    endfunction

    function automatic logic signed [16:0] pos_sum(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        logic signed [16:0] ae;
        logic signed [16:0] be;
        ae = a;
        be = b;
        return (ae[16] ? 17'sd0 : ae) + (be[16] ? 17'sd0 : be);
    endfunction

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_near_count;
    logic [CW-1:0]       r_near_limit;
    logic signed [19:0]  r_last_x, r_last_y, r_last_z;
    logic [15:0]         r_found;
    logic                r_refreshed;
    logic                r_full;
    logic                r_rebuild;
    logic                r_out_valid;
    t_out                r_out;
    logic signed [20:0]  r_dx, r_dy, r_dz;
    logic [41:0]         r_sqx, r_sqy, r_sqz;
    logic [27:0]         r_lim2;
    logic [CW-1:0]       r_issue_idx;

    t_zone               r_zone_mem [ZONES];
    logic                r_near_mem [ZONES];
    t_zone               r_rd_zone;
    logic                r_rd_near;

    // Sweep pipeline: read, bounds, products, compare.
    logic                r_v1, r_v2, r_v3;
    logic [IW-1:0]       r_idx1, r_idx2, r_idx3;
    logic signed [20:0]  r2_tx, r2_ty;
    logic signed [15:0]  r2_e1x, r2_e1y, r2_e2x, r2_e2y;
    logic signed [23:0]  r2_lox, r2_hix, r2_loy, r2_hiy, r2_loz, r2_hiz;
    logic                r2_zin, r2_near_prev;
    logic [15:0]         r2_flags;
    logic signed [36:0]  r3_p1, r3_p2, r3_p3, r3_p4;
    logic signed [31:0]  r3_q1, r3_q2, r3_q3, r3_q4;
    logic                r3_zin, r3_near_prev, r3_near;
    logic [15:0]         r3_flags;

    logic                zone_we;
    t_zone               new_zone;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                near_we;
    logic                sweep_done;
    logic [43:0]         dist2;
    logic [13:0]         lim;
    logic signed [23:0]  s1_m;
    logic signed [23:0]  px24, py24, pz24;
    logic signed [16:0]  s1_nx, s1_px, s1_ny, s1_py;
    logic signed [38:0]  s3_d1, s3_d2, s3_l1, s3_l2;
    logic                s3_hit;

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign zone_we = (r_state == ST_EXEC) && (r_cmd.op == OP_ADD) &&
                     (r_count < CW'(ZONES));
    assign rd_en   = (r_state == ST_SWEEP) && (r_issue_idx < r_count);
    assign rd_addr = r_issue_idx[IW-1:0];
    assign near_we = r_v3 && r_rebuild;
    assign sweep_done = (r_issue_idx == r_count) && !r_v1 && !r_v2 && !r_v3;

    always_comb begin
        new_zone.cx    = r_cmd.item.pos_x;
        new_zone.cy    = r_cmd.item.pos_y;
        new_zone.bot   = r_cmd.item.pos_z;
        new_zone.top16 = {r_cmd.item.top_z, 4'b0000};
        new_zone.e1x   = r_cmd.item.edge1_x;
        new_zone.e1y   = r_cmd.item.edge1_y;
        new_zone.e2x   = r_cmd.item.edge2_x;
        new_zone.e2y   = r_cmd.item.edge2_y;
        new_zone.flags = r_cmd.item.zone_flags;
    end

    always_comb begin
        lim   = {i_cfg.refresh_distance, 4'b0000};
        dist2 = 44'(r_sqx) + 44'(r_sqy) + 44'(r_sqz);
        s1_m  = signed'(24'({i_cfg.near_margin, 4'b0000}));
        px24  = 24'(r_cmd.item.pos_x);
        py24  = 24'(r_cmd.item.pos_y);
        pz24  = 24'(r_cmd.item.pos_z);
        s1_nx = neg_sum(r_rd_zone.e1x, r_rd_zone.e2x);
        s1_px = pos_sum(r_rd_zone.e1x, r_rd_zone.e2x);
        s1_ny = neg_sum(r_rd_zone.e1y, r_rd_zone.e2y);
        s1_py = pos_sum(r_rd_zone.e1y, r_rd_zone.e2y);
        s3_d1 = 39'(r3_p1) + 39'(r3_p2);
        s3_d2 = 39'(r3_p3) + 39'(r3_p4);
        s3_l1 = (39'(r3_q1) + 39'(r3_q2)) <<< 4;
        s3_l2 = (39'(r3_q3) + 39'(r3_q4)) <<< 4;
        s3_hit = r3_zin && r3_near_prev &&
                 !s3_d1[38] && (s3_d1 <= s3_l1) &&
                 !s3_d2[38] && (s3_d2 <= s3_l2);
    end

    always_ff @(posedge i_clk) begin
        if (zone_we) begin
            r_zone_mem[r_count[IW-1:0]] <= new_zone;
        end
        if (near_we) begin
            r_near_mem[r_idx3] <= r3_near;
        end
        if (rd_en) begin
            r_rd_zone <= r_zone_mem[rd_addr];
            r_rd_near <= r_near_mem[rd_addr];
        end
    end

    // Datapath of the sweep pipeline; only the valid bits carry reset.
    always_ff @(posedge i_clk) begin
        r_idx1 <= rd_addr;

        r_idx2       <= r_idx1;
        r2_tx        <= 21'(r_cmd.item.pos_x) - 21'(r_rd_zone.cx);
        r2_ty        <= 21'(r_cmd.item.pos_y) - 21'(r_rd_zone.cy);
        r2_e1x       <= r_rd_zone.e1x;
        r2_e1y       <= r_rd_zone.e1y;
        r2_e2x       <= r_rd_zone.e2x;
        r2_e2y       <= r_rd_zone.e2y;
        r2_lox       <= 24'(r_rd_zone.cx) + (24'(s1_nx) <<< 4) - s1_m;
        r2_hix       <= 24'(r_rd_zone.cx) + (24'(s1_px) <<< 4) + s1_m;
        r2_loy       <= 24'(r_rd_zone.cy) + (24'(s1_ny) <<< 4) - s1_m;
        r2_hiy       <= 24'(r_rd_zone.cy) + (24'(s1_py) <<< 4) + s1_m;
        r2_loz       <= 24'(r_rd_zone.bot) - s1_m;
        r2_hiz       <= 24'(r_rd_zone.top16) + s1_m;
        r2_zin       <= (r_cmd.item.pos_z > r_rd_zone.bot) &&
                        (r_cmd.item.pos_z < r_rd_zone.top16);
        r2_near_prev <= r_rd_near && (CW'(r_idx1) < r_near_limit);
        r2_flags     <= r_rd_zone.flags;

        r_idx3       <= r_idx2;
        r3_p1        <= r2_tx * r2_e1x;
        r3_p2        <= r2_ty * r2_e1y;
        r3_p3        <= r2_tx * r2_e2x;
        r3_p4        <= r2_ty * r2_e2y;
        r3_q1        <= r2_e1x * r2_e1x;
        r3_q2        <= r2_e1y * r2_e1y;
        r3_q3        <= r2_e2x * r2_e2x;
        r3_q4        <= r2_e2y * r2_e2y;
        r3_zin       <= r2_zin;
        r3_near_prev <= r2_near_prev;
        r3_near      <= (px24 > r2_lox) && (px24 < r2_hix) &&
                        (py24 > r2_loy) && (py24 < r2_hiy) &&
                        (pz24 > r2_loz) && (pz24 < r2_hiz);
        r3_flags     <= r2_flags;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == ST_EXEC) begin
            r_dx <= 21'(r_cmd.item.pos_x) - 21'(r_last_x);
            r_dy <= 21'(r_cmd.item.pos_y) - 21'(r_last_y);
            r_dz <= 21'(r_cmd.item.pos_z) - 21'(r_last_z);
        end
        if (r_state == ST_SQ) begin
            // The squares are sized by their targets (42 bits, 28 for the limit), so no bits are lost.
            r_sqx  <= r_dx * r_dx;
            r_sqy  <= r_dy * r_dy;
            r_sqz  <= r_dz * r_dz;
            r_lim2 <= lim * lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_near_count <= '0;
            r_near_limit <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_z     <= '0;
            r_found      <= '0;
            r_refreshed  <= 1'b0;
            r_full       <= 1'b0;
            r_rebuild    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_issue_idx  <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (rd_en) begin
                r_issue_idx <= r_issue_idx + 1'b1;
            end
            if (r_v3) begin
                if (r_rebuild) begin
                    r_near_count <= r_near_count + CW'(r3_near);
                end else if (s3_hit) begin
                    r_found <= r_found | r3_flags;
                end
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_found     <= '0;
                        r_refreshed <= 1'b0;
                        r_full      <= 1'b0;
                        r_state     <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (r_cmd.op)
                        OP_ADD: begin
                            if (zone_we) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_full <= 1'b1;
                            end
                            r_state <= ST_DONE;
                        end
                        OP_SKIP: begin
                            r_state <= ST_DONE;
                        end
                        OP_CAMERA: begin
                            r_state <= ST_SQ;
                        end
                        OP_QUERY: begin
                            r_rebuild   <= 1'b0;
                            r_issue_idx <= '0;
                            r_state     <= ST_SWEEP;
                        end
                    endcase
                end
                ST_SQ: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (dist2 > 44'(r_lim2)) begin
                        r_refreshed  <= 1'b1;
                        r_last_x     <= r_cmd.item.pos_x;
                        r_last_y     <= r_cmd.item.pos_y;
                        r_last_z     <= r_cmd.item.pos_z;
                        r_near_limit <= r_count;
                        r_near_count <= '0;
                        r_rebuild    <= 1'b1;
                        r_issue_idx  <= '0;
                        r_state      <= ST_SWEEP;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    if (sweep_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_out.found_flags <= r_found;
            r_out.refreshed   <= r_refreshed;
            r_out.table_full  <= r_full;
            r_out.zone_total  <= CNT_OUT_W'(r_count);
            r_out.near_total  <= CNT_OUT_W'(r_near_count);
        end
    end

endmodule

>>> hdl/zal_checker.sv
`include "zone_attribute_lookup_top_defines.svh"

module zal_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input zal_pkg::t_out o_out
);
    import zal_pkg::*;

    `ZAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    `ZAL_ASSERT_NOW(a_one_kind, i_clk, i_rst_n, o_out_valid, !(o_out.refreshed && o_out.table_full))
    `ZAL_ASSERT_NOW(a_no_found, i_clk, i_rst_n, o_out_valid && (o_out.refreshed || o_out.table_full), o_out.found_flags == 16'd0)

endmodule

bind zone_attribute_lookup_top zal_checker u_zal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> bench/zone_attribute_lookup_top_test.sv
`timescale 1ns / 1ps

module zone_attribute_lookup_top_test;
    import zal_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = ZONES_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    zone_attribute_lookup_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the zone table and its settings.
    longint    zcx[TABLE_DEPTH], zcy[TABLE_DEPTH], zbot[TABLE_DEPTH], ztop[TABLE_DEPTH];
    longint    ze1x[TABLE_DEPTH], ze1y[TABLE_DEPTH], ze2x[TABLE_DEPTH], ze2y[TABLE_DEPTH];
    logic [15:0] zflags[TABLE_DEPTH];
    bit        znear[TABLE_DEPTH];
    int        zone_count, near_count;
    longint    cam_x, cam_y, cam_z;
    logic [9:0]  refresh_dist;
    logic [9:0]  margin;
    logic [15:0] drop_mask;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   errors, gap_left, stall_left;
    bit   quiet;
    int   n_refresh, n_hits, n_full, n_results;

    // Corners of zones the stimulus has added, used to aim cameras and queries.
    int wcx[$], wcy[$], wbot[$], wtop[$], we1x[$], we1y[$], we2x[$], we2y[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("zone_attribute_lookup_top_test NOT OK");
        $finish;
    end

    function automatic bit zone_has_point(int k, longint px, longint py, longint pz);
        longint tx, ty, d1, d2;
        if (!(pz > zbot[k] && pz < ztop[k])) return 0;
        tx = px - zcx[k];
        ty = py - zcy[k];
        d1 = tx * ze1x[k] + ty * ze1y[k];
        if (d1 < 0 || d1 > 16 * (ze1x[k] * ze1x[k] + ze1y[k] * ze1y[k])) return 0;
        d2 = tx * ze2x[k] + ty * ze2y[k];
        if (d2 < 0 || d2 > 16 * (ze2x[k] * ze2x[k] + ze2y[k] * ze2y[k])) return 0;
        return 1;
    endfunction

    function automatic longint neg_part(longint a); return a < 0 ? a : 0; endfunction
    function automatic longint pos_part(longint a); return a > 0 ? a : 0; endfunction

    function automatic bit zone_is_near(int k, longint px, longint py, longint pz);
        longint m;
        m = 16 * longint'(margin);
        return px > zcx[k] + 16 * (neg_part(ze1x[k]) + neg_part(ze2x[k])) - m &&
               px < zcx[k] + 16 * (pos_part(ze1x[k]) + pos_part(ze2x[k])) + m &&
               py > zcy[k] + 16 * (neg_part(ze1y[k]) + neg_part(ze2y[k])) - m &&
               py < zcy[k] + 16 * (pos_part(ze1y[k]) + pos_part(ze2y[k])) + m &&
               pz > zbot[k] - m && pz < ztop[k] + m;
    endfunction

    task automatic lookup_step(input t_in it, output t_out r);
        longint px, py, pz, dx, dy, dz, lim;
        logic [15:0] fl;
        px = longint'($signed(it.pos_x));
        py = longint'($signed(it.pos_y));
        pz = longint'($signed(it.pos_z));
        r = '0;
        if (it.func == FUNC_ADD) begin
            fl = it.zone_flags & ~drop_mask;
            if (fl != 0) begin
                if (zone_count >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    zcx[zone_count] = px;
                    zcy[zone_count] = py;
                    zbot[zone_count] = pz;
                    ze1x[zone_count] = longint'($signed(it.edge1_x));
                    ze1y[zone_count] = longint'($signed(it.edge1_y));
                    ze2x[zone_count] = longint'($signed(it.edge2_x));
                    ze2y[zone_count] = longint'($signed(it.edge2_y));
                    ztop[zone_count] = 16 * longint'($signed(it.top_z));
                    zflags[zone_count] = fl;
                    zone_count++;
                end
            end
        end else if (it.func == FUNC_CAMERA) begin
            dx = px - cam_x;
            dy = py - cam_y;
            dz = pz - cam_z;
            lim = 16 * longint'(refresh_dist);
            if (dx * dx + dy * dy + dz * dz > lim * lim) begin
                r.refreshed = 1'b1;
                cam_x = px;
                cam_y = py;
                cam_z = pz;
                near_count = 0;
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    znear[k] = k < zone_count && zone_is_near(k, px, py, pz);
                    if (znear[k]) near_count++;
                end
            end
        end else if (it.func == FUNC_QUERY) begin
            for (int k = 0; k < zone_count; k++)
                if (znear[k] && zone_has_point(k, px, py, pz))
                    r.found_flags |= zflags[k];
        end
        r.zone_total = 9'(zone_count);
        r.near_total = 9'(near_count);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic put(logic [1:0] f, int px, int py, int pz, int a, int b, int c, int d,
                       int top, int fl);
        t_in it;
        it.func = f;
        it.pos_x = 20'(px);
        it.pos_y = 20'(py);
        it.pos_z = 20'(pz);
        it.edge1_x = 16'(a);
        it.edge1_y = 16'(b);
        it.edge2_x = 16'(c);
        it.edge2_y = 16'(d);
        it.top_z = 16'(top);
        it.zone_flags = 16'(fl);
        pending_items.push_back(it);
    endtask

    task automatic put_random();
        logic [159:0] raw;
        int sel, k, a, b, px, py, pz, e1x, e1y, e2x, e2y, bot, top;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            pending_items.push_back(t_in'(raw[157:0]));
        end else if (sel < 45 || wcx.size() == 0) begin
            px = $urandom_range(0, 4000) - 2000;
            py = $urandom_range(0, 4000) - 2000;
            bot = $urandom_range(0, 800) - 400;
            if ($urandom_range(0, 9) != 0) begin
                px = px & ~15;
                py = py & ~15;
                bot = bot & ~15;
            end
            e1x = $urandom_range(0, 40) - 20;
            e1y = $urandom_range(0, 40) - 20;
            e2x = $urandom_range(0, 40) - 20;
            e2y = $urandom_range(0, 40) - 20;
            top = bot / 16 + $urandom_range(0, 32) - 2;
            put(FUNC_ADD, px, py, bot, e1x, e1y, e2x, e2y, top,
                $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 65535));
            if (wcx.size() >= 64) begin
                k = $urandom_range(0, 63);
                wcx.delete(k); wcy.delete(k); wbot.delete(k); wtop.delete(k);
                we1x.delete(k); we1y.delete(k); we2x.delete(k); we2y.delete(k);
            end
            wcx.push_back(px); wcy.push_back(py); wbot.push_back(bot);
            wtop.push_back(top * 16);
            we1x.push_back(e1x); we1y.push_back(e1y);
            we2x.push_back(e2x); we2y.push_back(e2y);
        end else begin
            k = $urandom_range(0, wcx.size() - 1);
            if (sel < 65) begin
                if ($urandom_range(0, 4) == 0)
                    put(FUNC_CAMERA, $urandom_range(0, 6000) - 3000,
                        $urandom_range(0, 6000) - 3000, $urandom_range(0, 2000) - 1000,
                        0, 0, 0, 0, 0, 0);
                else
                    put(FUNC_CAMERA, wcx[k] + $urandom_range(0, 2400) - 1200,
                        wcy[k] + $urandom_range(0, 2400) - 1200,
                        wbot[k] + $urandom_range(0, 1200) - 600, 0, 0, 0, 0, 0, 0);
            end else begin
                a = $urandom_range(0, 16);
                b = $urandom_range(0, 16);
                px = wcx[k] + a * we1x[k] + b * we2x[k];
                py = wcy[k] + a * we1y[k] + b * we2y[k];
                pz = wbot[k] + $urandom_range(0, wtop[k] > wbot[k] ? wtop[k] - wbot[k] : 2);
                if ($urandom_range(0, 3) == 0) begin
                    px += $urandom_range(0, 4) - 2;
                    py += $urandom_range(0, 4) - 2;
                end
                put(FUNC_QUERY, px, py, pz, 0, 0, 0, 0, 0, 0);
            end
        end
    endtask

    // Leaves the write channel valid; the caller drops it after its last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_REFRESH) refresh_dist = data[9:0];
        else if (idx == CFG_MARGIN) margin = data[9:0];
        else if (idx == CFG_DROPPED) drop_mask = data;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic settings_phase(int rd, int mg, int dr, int items);
        drain();
        write_reg(CFG_REFRESH, CFG_DAT_W'(rd));
        write_reg(CFG_MARGIN, CFG_DAT_W'(mg));
        write_reg(CFG_DROPPED, CFG_DAT_W'(dr));
        i_cfg_valid <= 1'b0;
        quiet = $urandom_range(0, 3) == 0;
        for (int n = 0; n < items; n++) put_random();
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        if (errors <= 40)
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            lookup_step(i_in, r);
            expected_results.push_back(r);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= pick_gap();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (want.refreshed) n_refresh++;
                if (want.table_full) n_full++;
                if (want.found_flags != 0) n_hits++;
                if (o_out.found_flags !== want.found_flags)
                    report("found_flags", o_out.found_flags, want.found_flags);
                if (o_out.refreshed !== want.refreshed)
                    report("refreshed", o_out.refreshed, want.refreshed);
                if (o_out.table_full !== want.table_full)
                    report("table_full", o_out.table_full, want.table_full);
                if (o_out.zone_total !== want.zone_total)
                    report("zone_total", o_out.zone_total, want.zone_total);
                if (o_out.near_total !== want.near_total)
                    report("near_total", o_out.near_total, want.near_total);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        zone_count = 0;
        near_count = 0;
        cam_x = 0; cam_y = 0; cam_z = 0;
        refresh_dist = REFRESH_RST;
        margin = MARGIN_RST;
        drop_mask = DROPPED_RST;
        quiet = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) znear[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings.
        put(FUNC_ADD, 0, 0, 0, 10, 0, 0, 10, 5, 16'h0001);
        put(FUNC_ADD, 32, 32, 16, -3, 4, 4, 3, 3, 16'h8000);
        put(FUNC_ADD, 5, 7, 0, 0, 0, 0, 0, 2, 16'h0002);       // zero edges, odd corner
        put(FUNC_ADD, 0, 0, 100, 5, 5, 5, -5, 6, 16'h0004);    // empty vertical span
        put(FUNC_ADD, 0, 0, 0, 10, 10, 10, 10, 10, 16'h0000);  // no flags, ignored
        put(FUNC_ADD, 524287, -524288, -524288, 32767, -32768, 32767, -32768, 32767,
            16'hFFFF);
        put(FUNC_ADD, -524288, 524287, 524287, -32768, 32767, -32768, 32767, -32768,
            16'h5555);
        put(FUNC_CAMERA, 0, 0, 0, 0, 0, 0, 0, 0, 0);           // no movement
        put(FUNC_CAMERA, 200, 0, 0, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 80, 80, 40, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 160, 160, 40, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 5, 7, 1, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 80, 80, 0, 0, 0, 0, 0, 0, 0);          // on the bottom plane
        put(FUNC_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1, 16'hFFFF);
        put(FUNC_ADD, 0, 0, 0, 20, 0, 0, 20, 10, 16'h0100);    // after the rebuild
        put(FUNC_QUERY, 80, 80, 40, 0, 0, 0, 0, 0, 0);
        put(FUNC_CAMERA, -524288, -524288, -524288, 0, 0, 0, 0, 0, 0);
        put(FUNC_CAMERA, 524287, 524287, 524287, 0, 0, 0, 0, 0, 0);
        put(FUNC_CAMERA, 100, 100, 50, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 80, 80, 40, 0, 0, 0, 0, 0, 0);
        put(FUNC_QUERY, 524287, -524288, 524287, 0, 0, 0, 0, 0, 0);

        settings_phase(0, 0, 0, 300);
        settings_phase(1023, 1023, 0, 300);
        settings_phase(3, 5, 16'h00F0, 300);
        settings_phase(1023, 0, 16'hFFFF, 100);
        settings_phase(10, 30, 16'h8001, 250);
        drain();

        $display("%0d results checked: %0d rebuilds, %0d query hits, %0d refused adds,",
                 n_results, n_refresh, n_hits, n_full);
        $display("%0d zones stored at the end, five register settings", zone_count);
        if (errors == 0)
            $display("zone_attribute_lookup_top_test OK");
        else
            $display("zone_attribute_lookup_top_test NOT OK");
        $finish;
    end

endmodule
